@@ design/nlp_pkg.sv @@
// ----------------------------------------------------------------------------
// nlp_pkg
// Types, character codes and helpers for the number literal parser.
// ----------------------------------------------------------------------------
package nlp_pkg;

    typedef enum logic [2:0] {
        PH_START  = 3'd0,
        PH_ZERO   = 3'd1,
        PH_PREFIX = 3'd2,
        PH_DIGITS = 3'd3,
        PH_SIGN   = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        RX_DEC = 2'd0,
        RX_BIN = 2'd1,
        RX_OCT = 2'd2,
        RX_HEX = 2'd3
    } radix_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FORMAT = 2'd1,
        ST_RANGE  = 2'd2
    } status_t;

    localparam logic [0:0] REG_BIT_LENGTH  = 1'b0;
    localparam logic [0:0] REG_SIGNED_MODE = 1'b1;

    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CH_A_LO     = 8'h61;
    localparam logic [7:0] CH_F_LO     = 8'h66;
    localparam logic [7:0] CH_B_LO     = 8'h62;
    localparam logic [7:0] CH_X_LO     = 8'h78;
    localparam logic [7:0] CH_MINUS    = 8'h2d;
    localparam logic [7:0] CH_A_UP     = 8'h41;
    localparam logic [7:0] CH_Z_UP     = 8'h5a;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    localparam int ACC_W  = 33;
    localparam int PROD_W = 38;

    // digit value of a lower-case character, 16 when no digit at all
    function automatic logic [4:0] digit_value(input logic [7:0] c);
        logic [7:0] t;
        t = 8'd16;
        if (c >= CH_ZERO && c <= CH_NINE)
            t = c - CH_ZERO;
        else if (c >= CH_A_LO && c <= CH_F_LO)
            t = c - CH_A_LO + 8'd10;
        return t[4:0];
    endfunction

    function automatic logic [4:0] radix_value(input radix_t r);
        logic [4:0] t;
        unique case (r)
            RX_DEC: t = 5'd10;
            RX_BIN: t = 5'd2;
            RX_OCT: t = 5'd8;
            RX_HEX: t = 5'd16;
        endcase
        return t;
    endfunction

endpackage

@@ design/number_literal_parser.sv @@
// ----------------------------------------------------------------------------
// number_literal_parser
// Parses one assembler integer token (binary, octal, decimal, hex), one
// character per word, and gives the value and a status on the last one.
// ----------------------------------------------------------------------------
// One character is taken per clock cycle, back to back. A character word
// passes an input register, then one pass of shift-add accumulate and range
// check logic; on the last character the value and status are registered in
// an output register and wait there until taken. Only the output register
// can stall the input side, and only for last characters. The range
// settings are sampled when the last character is processed.
module number_literal_parser #(
    parameter int MAX_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] char_code
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,     // [31:0] value_bits, [33:32] status
    input  logic        cfg_we,
    input  logic [0:0]  cfg_addr,
    input  logic [5:0]  cfg_wdata
);
    import nlp_pkg::*;

    localparam logic [5:0] MAX_B = 6'(MAX_BITS);

    logic [5:0]       bit_length_reg;
    logic             signed_mode_reg;

    logic             in_valid_reg;
    logic [7:0]       in_char_reg;
    logic             in_last_reg;

    phase_t           phase_reg, phase_next;
    radix_t           radix_reg, radix_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic             ovf_reg, ovf_next;
    logic             neg_reg, neg_next;
    logic             ferr_reg, ferr_next;

    logic             out_valid_reg;
    logic [31:0]      value_reg, value_next;
    status_t          status_reg, status_next;

    logic             advance;
    logic [7:0]       c_fold;
    logic [4:0]       dig;
    radix_t           radix_eff;
    logic             digit_ok;
    logic             take;
    logic [PROD_W-1:0] acc_ext, prod, sum;
    logic [5:0]       b_eff;
    logic [33:0]      full, max_u, max_s, num, lim;
    logic [33:0]      wrap, negv;

    assign advance  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, status_reg, value_reg};

    // digit step
    always_comb
    begin
        c_fold = in_char_reg;
        if (in_char_reg >= CH_A_UP && in_char_reg <= CH_Z_UP)
            c_fold = in_char_reg + CASE_OFFSET;
        dig       = digit_value(c_fold);
        radix_eff = (phase_reg == PH_ZERO) ? RX_OCT : radix_reg;
        digit_ok  = dig < radix_value(radix_eff);
        acc_ext   = {{(PROD_W-ACC_W){1'b0}}, acc_reg};
        unique case (radix_eff)
            RX_DEC: prod = (acc_ext << 3) + (acc_ext << 1);
            RX_BIN: prod = acc_ext << 1;
            RX_OCT: prod = acc_ext << 3;
            RX_HEX: prod = acc_ext << 4;
        endcase
        sum = prod + {{(PROD_W-5){1'b0}}, dig};

        phase_next = phase_reg;
        radix_next = radix_reg;
        acc_next   = acc_reg;
        ovf_next   = ovf_reg;
        neg_next   = neg_reg;
        ferr_next  = ferr_reg;
        take       = 1'b0;
        if (!ferr_reg)
        begin
            unique case (phase_reg)
                PH_START:
                begin
                    if (c_fold == CH_ZERO)
                        phase_next = PH_ZERO;
                    else if (c_fold == CH_MINUS)
                    begin
                        neg_next   = 1'b1;
                        phase_next = PH_SIGN;
                    end
                    else
                        take = 1'b1;
                end
                PH_ZERO:
                begin
                    if (c_fold == CH_B_LO)
                    begin
                        radix_next = RX_BIN;
                        phase_next = PH_PREFIX;
                    end
                    else if (c_fold == CH_X_LO)
                    begin
                        radix_next = RX_HEX;
                        phase_next = PH_PREFIX;
                    end
                    else
                    begin
                        radix_next = RX_OCT;
                        take       = 1'b1;
                    end
                end
                PH_PREFIX, PH_SIGN, PH_DIGITS: take = 1'b1;
                default: ferr_next = 1'b1;
            endcase
        end
        if (take)
        begin
            if (!digit_ok)
                ferr_next = 1'b1;
            else
            begin
                acc_next   = sum[ACC_W-1:0];
                phase_next = PH_DIGITS;
                if (|sum[PROD_W-1:ACC_W])
                    ovf_next = 1'b1;
            end
        end
    end

    // end of token: range check
    always_comb
    begin
        b_eff = bit_length_reg;
        if (bit_length_reg == 6'd0)
            b_eff = 6'd1;
        else if (bit_length_reg > MAX_B)
            b_eff = MAX_B;
        full  = 34'd1 << b_eff;
        max_u = full - 34'd1;
        max_s = (34'd1 << (b_eff - 6'd1)) - 34'd1;
        num   = {1'b0, acc_next};
        wrap  = num - full;
        negv  = 34'd0 - num;
        lim   = signed_mode_reg ? max_s
              : ((b_eff == 6'd32) ? 34'h07fffffff : max_u);

        value_next  = 32'd0;
        status_next = ST_OK;
        priority if (ferr_next || phase_next == PH_PREFIX || phase_next == PH_SIGN ||
                     (neg_next && !signed_mode_reg))
            status_next = ST_FORMAT;
        else if (radix_next != RX_DEC)
        begin
            if (ovf_next || num > max_u)
                status_next = ST_RANGE;
            else if (signed_mode_reg && num > max_s)
                value_next = wrap[31:0];
            else
                value_next = num[31:0];
        end
        else if (neg_next)
        begin
            if (ovf_next || num > max_s + 34'd1)
                status_next = ST_RANGE;
            else
                value_next = negv[31:0];
        end
        else
        begin
            if (ovf_next || num > lim)
                status_next = ST_RANGE;
            else
                value_next = num[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_length_reg  <= 6'd32;
            signed_mode_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_BIT_LENGTH:  bit_length_reg  <= cfg_wdata;
                REG_SIGNED_MODE: signed_mode_reg <= cfg_wdata[0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            radix_reg <= RX_DEC;
            acc_reg   <= '0;
            ovf_reg   <= 1'b0;
            neg_reg   <= 1'b0;
            ferr_reg  <= 1'b0;
        end
        else if (advance)
        begin
            if (in_last_reg)
            begin
                phase_reg <= PH_START;
                radix_reg <= RX_DEC;
                acc_reg   <= '0;
                ovf_reg   <= 1'b0;
                neg_reg   <= 1'b0;
                ferr_reg  <= 1'b0;
            end
            else
            begin
                phase_reg <= phase_next;
                radix_reg <= radix_next;
                acc_reg   <= acc_next;
                ovf_reg   <= ovf_next;
                neg_reg   <= neg_next;
                ferr_reg  <= ferr_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
        begin
            if (out_valid_reg && m_tready)
                out_valid_reg <= 1'b0;
            if (advance && in_last_reg)
                out_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
        begin
            value_reg  <= value_next;
            status_reg <= status_next;
        end
    end

endmodule

@@ test/number_literal_parser_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// number_literal_parser_checker
// Follows the character and result streams of the number literal parser,
// predicts the value and status of each token and compares them in order.
// ----------------------------------------------------------------------------
module number_literal_parser_checker #(
    parameter int MAX_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_addr,
    input  logic [5:0]  cfg_wdata,
    output int          errors,
    output int          pending
);
    import nlp_pkg::*;

    localparam int EXP_DEPTH = 16;

    typedef struct packed {
        logic [31:0] value;
        status_t     status;
    } literal_t;

    literal_t    expected_literals[EXP_DEPTH];
    logic [3:0]  exp_head;
    logic [3:0]  exp_tail;
    int          exp_count;
    logic [5:0]  bit_length;
    logic        signed_mode;
    phase_t      phase;
    radix_t      radix;
    logic [32:0] acc;
    logic        overflow;
    logic        negative;
    logic        bad_format;

    function automatic int unsigned digit_of(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE)
            return 32'(c - CH_ZERO);
        if (c >= CH_A_LO && c <= CH_F_LO)
            return 32'(c - CH_A_LO) + 10;
        return 16;
    endfunction

    function automatic int unsigned base_of(input radix_t r);
        case (r)
            RX_BIN:  return 2;
            RX_OCT:  return 8;
            RX_HEX:  return 16;
            default: return 10;
        endcase
    endfunction

    task automatic clear_token();
        phase      = PH_START;
        radix      = RX_DEC;
        acc        = '0;
        overflow   = 1'b0;
        negative   = 1'b0;
        bad_format = 1'b0;
    endtask

    task automatic add_digit(input logic [7:0] c);
        int unsigned d;
        int unsigned r;
        logic [63:0] prod;
        d = digit_of(c);
        r = base_of(radix);
        if (d >= r) begin
            bad_format = 1'b1;
        end
        else begin
            prod = {31'd0, acc} * 64'(r) + 64'(d);
            if (prod[63:33] != 0)
                overflow = 1'b1;
            acc   = prod[32:0];
            phase = PH_DIGITS;
        end
    endtask

    function automatic literal_t token_result();
        literal_t    res;
        int unsigned b;
        logic [63:0] num;
        logic [63:0] full;
        logic [63:0] max_u;
        logic [63:0] max_s;
        logic [63:0] lim;
        logic [63:0] tmp;
        res.value  = '0;
        res.status = ST_OK;
        num = {31'd0, acc};
        b   = 32'(bit_length);
        if (b < 1)
            b = 1;
        if (b > MAX_BITS)
            b = MAX_BITS;
        full  = 64'd1 << b;
        max_u = full - 64'd1;
        max_s = (64'd1 << (b - 1)) - 64'd1;
        if (bad_format || phase == PH_PREFIX || phase == PH_SIGN ||
            (negative && !signed_mode)) begin
            res.status = ST_FORMAT;
        end
        else if (radix != RX_DEC) begin
            if (overflow || num > max_u) begin
                res.status = ST_RANGE;
            end
            else if (signed_mode && num > max_s) begin
                tmp = num - full;
                res.value = tmp[31:0];
            end
            else begin
                res.value = num[31:0];
            end
        end
        else if (negative) begin
            if (overflow || num > max_s + 64'd1) begin
                res.status = ST_RANGE;
            end
            else begin
                tmp = 64'd0 - num;
                res.value = tmp[31:0];
            end
        end
        else begin
            if (signed_mode)
                lim = max_s;
            else if (b == 32)
                lim = 64'h7fff_ffff;
            else
                lim = max_u;
            if (overflow || num > lim)
                res.status = ST_RANGE;
            else
                res.value = num[31:0];
        end
        return res;
    endfunction

    task automatic save_expected(input literal_t lit);
        if (exp_count == EXP_DEPTH) begin
            errors++;
            if (errors <= 10)
                $display("too many results outstanding");
        end
        else begin
            expected_literals[exp_tail] = lit;
            exp_tail  = exp_tail + 4'd1;
            exp_count = exp_count + 1;
        end
    endtask

    task automatic take_char(input logic [7:0] raw, input logic last_in);
        logic [7:0] c;
        c = raw;
        if (c >= CH_A_UP && c <= CH_Z_UP)
            c = c + CASE_OFFSET;
        if (!bad_format) begin
            case (phase)
                PH_START: begin
                    if (c == CH_ZERO) begin
                        phase = PH_ZERO;
                    end
                    else if (c == CH_MINUS) begin
                        negative = 1'b1;
                        phase    = PH_SIGN;
                    end
                    else begin
                        add_digit(c);
                    end
                end
                PH_ZERO: begin
                    if (c == CH_B_LO) begin
                        radix = RX_BIN;
                        phase = PH_PREFIX;
                    end
                    else if (c == CH_X_LO) begin
                        radix = RX_HEX;
                        phase = PH_PREFIX;
                    end
                    else begin
                        radix = RX_OCT;
                        add_digit(c);
                    end
                end
                PH_PREFIX, PH_SIGN, PH_DIGITS: add_digit(c);
                default: bad_format = 1'b1;
            endcase
        end
        if (last_in) begin
            save_expected(token_result());
            clear_token();
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        literal_t want;
        if (!rst_n) begin
            exp_head    = '0;
            exp_tail    = '0;
            exp_count   = 0;
            bit_length  = 6'd32;
            signed_mode = 1'b1;
            clear_token();
            errors  = 0;
            pending = 0;
        end
        else begin
            if (cfg_we) begin
                if (cfg_addr == REG_BIT_LENGTH)
                    bit_length = cfg_wdata;
                else
                    signed_mode = cfg_wdata[0];
            end
            if (s_tvalid && s_tready)
                take_char(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                if (exp_count == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result: value %h status %0d",
                                 m_tdata[31:0], m_tdata[33:32]);
                end
                else begin
                    want      = expected_literals[exp_head];
                    exp_head  = exp_head + 4'd1;
                    exp_count = exp_count - 1;
                    if (m_tdata[31:0] !== want.value ||
                        m_tdata[33:32] !== want.status) begin
                        errors++;
                        if (errors <= 10)
                            $display({"mismatch: expected value %h status %0d, ",
                                      "got value %h status %0d"},
                                     want.value, want.status,
                                     m_tdata[31:0], m_tdata[33:32]);
                    end
                end
            end
            pending = exp_count;
        end
    end

endmodule

@@ test/number_literal_parser_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// number_literal_parser_test
// Feeds number tokens one character per word, mostly well-formed literals
// near the range limits with some noise and broken tokens, under changing
// range settings and random idling on both sides.
// ----------------------------------------------------------------------------
module number_literal_parser_test;
    import nlp_pkg::*;

    localparam int MAX_BITS    = 32;
    localparam int ITEM_TARGET = 1350;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic [0:0]  cfg_addr = REG_BIT_LENGTH;
    logic [5:0]  cfg_wdata = '0;

    int          errors;
    int          pending;
    int unsigned src_idle_pct = 13;
    int unsigned sink_idle_pct = 73;
    logic [7:0]  token_chars[$];

    number_literal_parser #(
        .MAX_BITS(MAX_BITS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_we(cfg_we),
        .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    number_literal_parser_checker #(
        .MAX_BITS(MAX_BITS)
    ) literal_check (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_we(cfg_we),
        .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata),
        .errors(errors),
        .pending(pending)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin
        #2_000_000;
        $display("number_literal_parser_test failed");
        $finish;
    end

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= sink_idle_pct);

    task automatic send_char(input logic [7:0] c, input logic last_in);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last_in;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic send_token();
        foreach (token_chars[i])
            send_char(token_chars[i], i == token_chars.size() - 1);
    endtask

    task automatic send_text(input string s);
        token_chars.delete();
        for (int i = 0; i < s.len(); i++)
            token_chars = {token_chars, s[i]};
        send_token();
    endtask

    // all results in and the pipeline empty
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic set_range(input logic [5:0] bit_len, input logic sgn);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_BIT_LENGTH;
        cfg_wdata <= bit_len;
        @(posedge clk);
        cfg_addr  <= REG_SIGNED_MODE;
        cfg_wdata <= {5'd0, sgn};
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic make_token();
        logic [63:0] v;
        logic [7:0]  digits[$];
        logic [7:0]  ch;
        int unsigned form;
        int unsigned base;
        int unsigned k;
        int unsigned d;
        token_chars.delete();
        if ($urandom_range(99) < 10) begin
            repeat ($urandom_range(1, 6))
                token_chars = {token_chars, 8'($urandom_range(255))};
            return;
        end
        k = $urandom_range(1, 40);
        case ($urandom_range(2))
            0:       v = {$urandom, $urandom} >> (64 - k);
            1:       v = (64'd1 << k) - 64'd2 + 64'($urandom_range(4));
            default: v = 64'($urandom_range(20));
        endcase
        form = $urandom_range(4);
        case (form)
            0, 1:    base = 10;
            2:       base = 2;
            3:       base = 8;
            default: base = 16;
        endcase
        do begin
            d  = 32'(v % 64'(base));
            ch = (d < 10) ? CH_ZERO + 8'(d) : CH_A_LO + 8'(d - 10);
            if (ch >= CH_A_LO && $urandom_range(1))
                ch = ch - CASE_OFFSET;
            digits = {ch, digits};
            v = v / 64'(base);
        end while (v != 0);
        if (form >= 2)
            repeat ($urandom_range(2)) digits = {CH_ZERO, digits};
        case (form)
            1: token_chars = {token_chars, CH_MINUS};
            2: begin
                ch = $urandom_range(1) ? CH_B_LO : CH_B_LO - CASE_OFFSET;
                token_chars = {token_chars, CH_ZERO, ch};
            end
            3: token_chars = {token_chars, CH_ZERO};
            4: begin
                ch = $urandom_range(1) ? CH_X_LO : CH_X_LO - CASE_OFFSET;
                token_chars = {token_chars, CH_ZERO, ch};
            end
            default: ;
        endcase
        token_chars = {token_chars, digits};
        // broken tokens: a stray character or a cut-off tail
        d = $urandom_range(99);
        if (d < 8)
            token_chars[$urandom_range(token_chars.size() - 1)] = 8'($urandom_range(255));
        else if (d < 14)
            token_chars = token_chars[0:$urandom_range(token_chars.size() - 1)];
    endtask

    initial begin
        logic [5:0] bit_len;
        int         tokens_left;
        int         items_sent;
        tokens_left = 0;
        items_sent  = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_range(6'd32, 1'b1);
        send_text("0");
        send_text("0B");
        send_text("0x");
        send_text("-");
        send_text("0X1f");
        send_text("0b9");
        send_text("017");
        send_text("-8");
        token_chars = '{8'h00, 8'hff};
        send_token();
        wait_idle();
        set_range(6'd0, 1'b0);
        send_text("-1");
        send_text("1");
        wait_idle();
        set_range(6'd63, 1'b1);

        while (items_sent < ITEM_TARGET) begin
            if (items_sent < ITEM_TARGET / 3) begin
                src_idle_pct  = 13;
                sink_idle_pct = 73;
            end
            else if (items_sent < 2 * ITEM_TARGET / 3) begin
                src_idle_pct  = 73;
                sink_idle_pct = 13;
            end
            else begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            if (tokens_left == 0) begin
                wait_idle();
                if ($urandom_range(3) == 0) begin
                    case ($urandom_range(3))
                        0:       bit_len = 6'd0;
                        1:       bit_len = 6'd1;
                        2:       bit_len = 6'd32;
                        default: bit_len = 6'd63;
                    endcase
                end
                else if ($urandom_range(4) == 0) begin
                    bit_len = 6'($urandom_range(63));
                end
                else begin
                    bit_len = 6'($urandom_range(1, 32));
                end
                set_range(bit_len, 1'($urandom_range(1)));
                tokens_left = $urandom_range(4, 12);
            end
            make_token();
            send_token();
            items_sent += token_chars.size();
            tokens_left--;
        end

        wait_idle();
        if (errors == 0 && pending == 0)
            $display("number_literal_parser_test passed");
        else
            $display("number_literal_parser_test failed");
        $finish;
    end

endmodule
